FILE: rtl/crt_scanline_dimmer_unit_macros.svh
// ----------------------------------------------------------------------------
// CRT scanline dimmer: assertion macros
// Shorthand for the concurrent checks in the top level. They sample on clk_i
// and are held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CRT_SCANLINE_DIMMER_UNIT_MACROS_SVH
`define CRT_SCANLINE_DIMMER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRTSD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRTSD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/crtsd_pkg.sv
// ----------------------------------------------------------------------------
// CRT scanline dimmer package
// Shared constants, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package crtsd_pkg;

  localparam int unsigned MAX_ROW_WIDTH_DEF = 4096;
  localparam int unsigned DIM_SHIFT_DEF     = 1;

  localparam int unsigned PIX_W       = 32;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned ROW_WIDTH_W = 13;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 13'd320;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SCANLINE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH       = 2'd1;

  // Luminance weights, scaled by 256.
  localparam logic [CH_W-1:0] LUM_R_COEF = 8'd77;
  localparam logic [CH_W-1:0] LUM_G_COEF = 8'd150;
  localparam logic [CH_W-1:0] LUM_B_COEF = 8'd29;
  localparam logic [CH_W-1:0] CH_MAX     = 8'hFF;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             dim;
    logic             odd;
  } crtsd_item_t;

endpackage

`default_nettype wire

FILE: rtl/crtsd_front.sv
// ----------------------------------------------------------------------------
// CRT scanline dimmer: front end
// Accepts pixels, tracks column and row parity, and tags each pixel as
// pass-through or dimmed before handing it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module crtsd_front import crtsd_pkg::*; #(
  parameter int unsigned MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic [PIX_W-1:0]       pixel_in_i,
  input  wire logic                   start_of_frame_i,
  input  wire logic                   scanline_enable_i,
  input  wire logic [ROW_WIDTH_W-1:0] row_width_i,
  input  wire logic                   q_full_i,
  output logic                        in_stall_o,
  output logic                        push_o,
  output crtsd_item_t                 item_o
);

  localparam int unsigned CntW = $clog2(MAX_ROW_WIDTH);
  localparam int unsigned WW   = (CntW + 1 > ROW_WIDTH_W) ? CntW + 1 : ROW_WIDTH_W;
  localparam logic [WW-1:0] MaxWidth = WW'(MAX_ROW_WIDTH);

  logic [CntW-1:0] col_q, col_d, col_cur;
  logic            par_q, par_d, par_cur;
  logic [WW-1:0]   rw_ext, eff_width, col_inc;
  logic            wrap;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    rw_ext = WW'(row_width_i);
    // A zero width counts as one pixel per row; larger widths saturate.
    if (rw_ext == '0) begin
      eff_width = WW'(1);
    end else if (rw_ext > MaxWidth) begin
      eff_width = MaxWidth;
    end else begin
      eff_width = rw_ext;
    end

    col_cur = start_of_frame_i ? '0 : col_q;
    par_cur = start_of_frame_i ? 1'b0 : par_q;

    col_inc = WW'(col_cur) + WW'(1);
    // A width lowered below the current column also ends the row here.
    wrap    = (col_inc >= eff_width);
    col_d   = wrap ? '0 : col_inc[CntW-1:0];
    par_d   = par_cur ^ wrap;

    item_o.pixel = pixel_in_i;
    item_o.dim   = scanline_enable_i && par_cur;
    item_o.odd   = par_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      par_q <= 1'b0;
    end else if (push_o) begin
      col_q <= col_d;
      par_q <= par_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/crtsd_queue.sv
// ----------------------------------------------------------------------------
// CRT scanline dimmer: decoupling queue
// Short register queue between the front end and the dimming pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module crtsd_queue import crtsd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  crtsd_item_t      item_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             valid_o,
  output crtsd_item_t      item_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  crtsd_item_t     store_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/crtsd_back.sv
// ----------------------------------------------------------------------------
// CRT scanline dimmer: dimming pipeline
// Two stages: luminance, then the per-channel blend into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crtsd_back import crtsd_pkg::*; #(
  parameter int unsigned DIM_SHIFT = DIM_SHIFT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  crtsd_item_t      item_i,
  output logic             pop_o,
  input  wire logic        out_stall_i,
  output logic             out_valid_o,
  output logic [PIX_W-1:0] pixel_out_o,
  output logic             odd_row_o
);

  localparam int unsigned NumCh = 3;

  logic              s1_v_q, s2_v_q;
  crtsd_item_t       s1_item_q;
  logic [CH_W-1:0]   s1_lum_q, lum_d;
  logic [PIX_W-1:0]  s2_pix_q, blend_pix;
  logic              s2_odd_q;
  logic              en1, en2;
  logic [2*CH_W-1:0] lum_sum;
  logic [CH_W-1:0]   ch_val, ch_half;
  logic [2*CH_W:0]   mix;

  assign en2   = !s2_v_q || !out_stall_i;
  assign en1   = !s1_v_q || en2;
  assign pop_o = q_valid_i && en1;

  always_comb begin
    lum_sum = (2*CH_W)'(item_i.pixel[31:24]) * (2*CH_W)'(LUM_R_COEF)
            + (2*CH_W)'(item_i.pixel[23:16]) * (2*CH_W)'(LUM_G_COEF)
            + (2*CH_W)'(item_i.pixel[15:8])  * (2*CH_W)'(LUM_B_COEF);
    lum_d   = lum_sum[2*CH_W-1:CH_W];
  end

  // Red, green and blue sit in the top three bytes; alpha passes through.
  always_comb begin
    ch_val  = '0;
    ch_half = '0;
    mix     = '0;
    blend_pix = s1_item_q.pixel;
    for (int i = 0; i < NumCh; i++) begin
      ch_val  = s1_item_q.pixel[CH_W*(i+1) +: CH_W];
      ch_half = ch_val >> DIM_SHIFT;
      mix     = (2*CH_W+1)'(ch_half) * (2*CH_W+1)'(CH_MAX - s1_lum_q)
              + (2*CH_W+1)'(ch_val) * (2*CH_W+1)'(s1_lum_q);
      blend_pix[CH_W*(i+1) +: CH_W] = mix[2*CH_W-1:CH_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_q <= q_valid_i;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_item_q <= item_i;
      s1_lum_q  <= lum_d;
    end
    if (en2 && s1_v_q) begin
      s2_pix_q <= s1_item_q.dim ? blend_pix : s1_item_q.pixel;
      s2_odd_q <= s1_item_q.odd;
    end
  end

  assign out_valid_o = s2_v_q;
  assign pixel_out_o = s2_pix_q;
  assign odd_row_o   = s2_odd_q;

endmodule

`default_nettype wire

FILE: rtl/crt_scanline_dimmer_unit.sv
// ----------------------------------------------------------------------------
// CRT scanline dimmer unit
// Pixels enter on a valid/stall channel with a start-of-frame mark and leave
// on a second valid/stall channel with an odd-row flag. A transaction on the
// input moves one RGBA8888 pixel; each produces exactly one output
// transaction, in order. On odd rows, with scanlines enabled, each colour
// channel is blended between its value shifted right by DIM_SHIFT (half
// by default) and its full value by the pixel luminance. A pixel is
// written into the queue at its input edge, then passes through the
// luminance stage into the blend/output register, which drives output
// valid. Throughput is one pixel per cycle while the output is not
// stalled; a two-entry queue separates the front end from the pipeline. A
// stall on the output freezes the pipeline, the queue then fills and
// in_stall_o rises. Reset clears the column count, row parity, queue and
// pipeline valid bits, disables scanlines and sets the row width to 320.
// Configuration writes take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crt_scanline_dimmer_unit_macros.svh"

module crt_scanline_dimmer_unit import crtsd_pkg::*; #(
  parameter int unsigned MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF,
  parameter int unsigned DIM_SHIFT     = DIM_SHIFT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [PIX_W-1:0]      pixel_in_i,
  input  wire logic                  start_of_frame_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [PIX_W-1:0]           pixel_out_o,
  output logic                       odd_row_o
);

  logic                   scanline_enable_q;
  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic                   push, q_full, q_valid, pop;
  crtsd_item_t            push_item, pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scanline_enable_q <= 1'b0;
      row_width_q       <= ROW_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCANLINE_ENABLE: scanline_enable_q <= cfg_wdata_i[0];
        CFG_ROW_WIDTH:       row_width_q       <= cfg_wdata_i[ROW_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  crtsd_front #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .pixel_in_i       (pixel_in_i),
    .start_of_frame_i (start_of_frame_i),
    .scanline_enable_i(scanline_enable_q),
    .row_width_i      (row_width_q),
    .q_full_i         (q_full),
    .in_stall_o       (in_stall_o),
    .push_o           (push),
    .item_o           (push_item)
  );

  crtsd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (pop_item)
  );

  crtsd_back #(
    .DIM_SHIFT(DIM_SHIFT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .item_i     (pop_item),
    .pop_o      (pop),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .pixel_out_o(pixel_out_o),
    .odd_row_o  (odd_row_o)
  );

  `CRTSD_ASSERT_IMP(a_sof_even_row, push && start_of_frame_i, !push_item.odd, "SOF pixel not on even row")
  `CRTSD_ASSERT_IMP(a_dim_needs_odd, push && push_item.dim, push_item.odd && scanline_enable_q, "dim tag without odd row and enable")
  `CRTSD_ASSERT_IMP(a_pop_nonempty, pop, q_valid, "queue popped while empty")
  `CRTSD_ASSERT_NXT(a_push_visible, push && !pop, q_valid, "pushed entry not visible in queue")

endmodule

`default_nettype wire
